### rtl/ssis_pkg.sv
package ssis_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAIT_POWER, PH_DUMMY,
    PH_CMD0_TX, PH_CMD0_RESP,
    PH_CMD8_TX, PH_CMD8_RESP, PH_CMD8_R7,
    PH_OCR1_TX, PH_OCR1_RESP, PH_OCR1_R7,
    PH_CMD55_TX, PH_CMD55_RESP,
    PH_ACMD41_TX, PH_ACMD41_RESP, PH_WAIT_OPCOND,
    PH_OCR2_TX, PH_OCR2_RESP, PH_OCR2_R7,
    PH_DONE, PH_ABORT
  } phase_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    REG_DUMMY   = 3'd0,
    REG_IFCOND  = 3'd1,
    REG_OPCOND  = 3'd2,
    REG_VMASK   = 3'd3,
    REG_POLLLIM = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    DLY_NONE  = 2'd0,
    DLY_SHORT = 2'd1,
    DLY_LONG  = 2'd2
  } delay_t;

  localparam int QueueDepth = 2;

  localparam logic [5:0] IDX_CMD0   = 6'd0;
  localparam logic [5:0] IDX_CMD8   = 6'd8;
  localparam logic [5:0] IDX_CMD55  = 6'd55;
  localparam logic [5:0] IDX_ACMD41 = 6'd41;
  localparam logic [5:0] IDX_CMD58  = 6'd58;
  localparam logic [7:0] CmdPrefix  = 8'h40;
  localparam logic [7:0] IdleByte   = 8'hFF;
  localparam logic [7:0] R1Idle     = 8'h01;
  localparam logic [7:0] R1Ready    = 8'h00;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic       start;
    logic       is_byte;
    logic       is_delay;
    logic [7:0] rx_byte;
  } op_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        select_active;
    logic [1:0]  delay_request;
    logic        sequence_done;
    logic        aborted;
    logic        reset_ok;
    logic        if_cond_ok;
    logic        voltage_ok;
    logic        response_timeout;
    logic [31:0] ocr_value;
  } result_t;

  // Serial CRC7 (x^7 + x^3 + 1), eight bits per call.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ c[6];
      c = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction

endpackage

### rtl/ssis_if.sv
interface ssis_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface ssis_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        select_active;
  logic [1:0]  delay_request;
  logic        sequence_done;
  logic        aborted;
  logic        reset_ok;
  logic        if_cond_ok;
  logic        voltage_ok;
  logic        response_timeout;
  logic [31:0] ocr_value;
  modport source (output valid, tx_valid, tx_byte, select_active, delay_request,
                  sequence_done, aborted, reset_ok, if_cond_ok, voltage_ok,
                  response_timeout, ocr_value, input ready);
  modport sink (input valid, tx_valid, tx_byte, select_active, delay_request,
                sequence_done, aborted, reset_ok, if_cond_ok, voltage_ok,
                response_timeout, ocr_value, output ready);
endinterface

interface ssis_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/sd_spi_init_sequencer.sv
// SD card SPI-mode power-up sequencer.
// in channel: command (start, byte exchanged, delay elapsed) plus the MISO
//   byte of the last exchange. out channel: one item per input item saying
//   which byte to exchange next (with chip select), which wait to time, and
//   the sticky outcome flags and final OCR.
// cfg channel: register index 0..4 and data, always ready; write only while
//   the block is idle.
// Throughput: one item per cycle while the receiver takes results. Order: an
//   accepted item is first written into the input queue, then the sequencing
//   step updates the phase, counters and CRC7 (one byte folded per item) and
//   registers the result in the output register.
// The two-entry input queue and the output register let the input side keep
//   going while the receiver stalls; when both fill, in_ready drops.
// Reset: phase idle, flags and OCR cleared, registers to their defaults
//   (10 dummy bytes, CMD8 arg 0x1AA, ACMD41 arg 0x40000000, mask 0x00380000,
//   poll limit 255). A start item restarts the sequence at any time.
module sd_spi_init_sequencer #(
  parameter int QDepth = ssis_pkg::QueueDepth
) (
  input logic   clk,
  input logic   rst_n,
  ssis_in_if.sink    in_ch,
  ssis_out_if.source out_ch,
  ssis_cfg_if.sink   cfg_ch
);
  import ssis_pkg::*;

  logic        q_valid, q_ready;
  op_t         q_op;
  result_t     res;
  logic        res_valid;
  logic [7:0]  dummy_r;
  logic [31:0] ifc_r, opc_r, vmask_r;
  logic [15:0] plim_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dummy_r <= 8'd10;
      ifc_r   <= 32'h0000_01AA;
      opc_r   <= 32'h4000_0000;
      vmask_r <= 32'h0038_0000;
      plim_r  <= 16'd255;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_DUMMY:   dummy_r <= cfg_ch.data[7:0];
        REG_IFCOND:  ifc_r   <= cfg_ch.data;
        REG_OPCOND:  opc_r   <= cfg_ch.data;
        REG_VMASK:   vmask_r <= cfg_ch.data;
        REG_POLLLIM: plim_r  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  ssis_front #(.Depth(QDepth)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_rx_byte(in_ch.rx_byte),
    .q_valid, .q_ready, .q_op
  );

  ssis_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_op,
    .init_dummy_bytes(dummy_r), .if_cond_argument(ifc_r),
    .op_cond_argument(opc_r), .voltage_window_mask(vmask_r),
    .response_poll_limit(plim_r),
    .res_valid, .res_ready(out_ch.ready), .res
  );

  assign out_ch.valid            = res_valid;
  assign out_ch.tx_valid         = res.tx_valid;
  assign out_ch.tx_byte          = res.tx_byte;
  assign out_ch.select_active    = res.select_active;
  assign out_ch.delay_request    = res.delay_request;
  assign out_ch.sequence_done    = res.sequence_done;
  assign out_ch.aborted          = res.aborted;
  assign out_ch.reset_ok         = res.reset_ok;
  assign out_ch.if_cond_ok       = res.if_cond_ok;
  assign out_ch.voltage_ok       = res.voltage_ok;
  assign out_ch.response_timeout = res.response_timeout;
  assign out_ch.ocr_value        = res.ocr_value;

  a_abort_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.aborted |-> out_ch.sequence_done) else $error("abort without done");
  a_tx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.tx_valid |-> out_ch.tx_byte == 8'd0 && !out_ch.select_active)
    else $error("tx byte without exchange");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.ocr_value))
    else $error("result lost under stall");

endmodule

### rtl/ssis_front.sv
module ssis_front #(
  parameter int Depth = ssis_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_command,
  input  logic [7:0]      in_rx_byte,
  output logic            q_valid,
  input  logic            q_ready,
  output ssis_pkg::op_t   q_op
);
  import ssis_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  op_t            mem_r [Depth];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  op_t            op_new;
  logic           push, pop;

  always_comb begin
    op_new.start    = (command_t'(in_command) == CMD_START);
    op_new.is_byte  = (command_t'(in_command) == CMD_BYTE);
    op_new.is_delay = (command_t'(in_command) == CMD_DELAY);
    op_new.rx_byte  = in_rx_byte;
  end

  assign in_ready = (cnt_r != (AW+1)'(Depth));
  assign q_valid  = (cnt_r != '0);
  assign q_op     = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ((wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? ((rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= op_new;
  end

endmodule

### rtl/ssis_back.sv
module ssis_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  ssis_pkg::op_t     q_op,
  input  logic [7:0]        init_dummy_bytes,
  input  logic [31:0]       if_cond_argument,
  input  logic [31:0]       op_cond_argument,
  input  logic [31:0]       voltage_window_mask,
  input  logic [15:0]       response_poll_limit,
  output logic              res_valid,
  input  logic              res_ready,
  output ssis_pkg::result_t res
);
  import ssis_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [39:0] frame_r, frame_nxt;
  logic [6:0]  crc_r, crc_nxt;
  logic [31:0] word_r, word_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic        f_rst_r, f_rst_nxt, f_ifc_r, f_ifc_nxt;
  logic        f_volt_r, f_volt_nxt, f_to_r, f_to_nxt;
  logic [31:0] ocr_r, ocr_nxt;
  logic        res_valid_r;
  result_t     res_r, res_nxt;
  logic        take;
  logic [7:0]  r;
  logic        got_resp;
  logic [7:0]  bc_inc;
  logic [15:0] poll_inc;
  logic [31:0] word_sh;

  // Output register frees as the sink takes the previous item.
  assign q_ready   = !res_valid_r || res_ready;
  assign take      = q_valid && q_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // The CRC is kept per byte: it is folded over the frame as it goes out.
  always_comb begin
    ph_nxt     = ph_r;
    bc_nxt     = bc_r;
    frame_nxt  = frame_r;
    crc_nxt    = crc_r;
    word_nxt   = word_r;
    poll_nxt   = poll_r;
    f_rst_nxt  = f_rst_r;
    f_ifc_nxt  = f_ifc_r;
    f_volt_nxt = f_volt_r;
    f_to_nxt   = f_to_r;
    ocr_nxt    = ocr_r;
    bc_inc     = bc_r + 8'd1;
    poll_inc   = poll_r + 16'd1;
    word_sh    = {word_r[23:0], q_op.rx_byte};
    got_resp   = 1'b0;
    r          = q_op.rx_byte;

    if (q_op.start) begin
      f_rst_nxt = 1'b0; f_ifc_nxt = 1'b0; f_volt_nxt = 1'b0; f_to_nxt = 1'b0;
      ocr_nxt = '0; word_nxt = '0; poll_nxt = '0; bc_nxt = '0;
      ph_nxt = PH_WAIT_POWER;
    end else if (q_op.is_byte) begin
      case (ph_r)
        PH_DUMMY: begin
          bc_nxt = bc_inc;
          if (bc_inc >= init_dummy_bytes || bc_inc == 8'd0) begin
            frame_nxt = {CmdPrefix | {2'b00, IDX_CMD0}, 32'd0};
            crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_CMD0_TX;
          end
        end
        PH_CMD0_TX, PH_CMD8_TX, PH_OCR1_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_OCR2_TX: begin
          bc_nxt = bc_inc;
          if (bc_r < 8'd5) crc_nxt = crc7_byte(crc_r, frame_r[39:32]);
          frame_nxt = {frame_r[31:0], 8'h00};
          if (bc_inc >= 8'd6) begin
            poll_nxt = '0;
            ph_nxt = phase_t'(ph_r + 5'd1);
          end
        end
        PH_CMD0_RESP, PH_CMD8_RESP, PH_OCR1_RESP, PH_CMD55_RESP, PH_ACMD41_RESP,
        PH_OCR2_RESP: begin
          if (r != IdleByte) begin
            got_resp = 1'b1;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= response_poll_limit) begin
              f_to_nxt = 1'b1;
              got_resp = 1'b1;
            end
          end
        end
        PH_CMD8_R7, PH_OCR1_R7, PH_OCR2_R7: begin
          word_nxt = word_sh;
          bc_nxt = bc_inc;
          if (bc_inc >= 8'd4) begin
            case (ph_r)
              PH_CMD8_R7: begin
                if (word_sh == if_cond_argument) f_ifc_nxt = 1'b1;
                frame_nxt = {CmdPrefix | {2'b00, IDX_CMD58}, 32'd0};
                crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_OCR1_TX;
              end
              PH_OCR1_R7: begin
                if (word_sh != '0 && (word_sh & voltage_window_mask) == voltage_window_mask)
                  f_volt_nxt = 1'b1;
                frame_nxt = {CmdPrefix | {2'b00, IDX_CMD55}, 32'd0};
                crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_CMD55_TX;
              end
              default: begin
                ocr_nxt = word_sh; ph_nxt = PH_DONE;
              end
            endcase
          end
        end
        default: ;
      endcase

      if (got_resp) begin
        case (ph_r)
          PH_CMD0_RESP: begin
            if (r == R1Idle) f_rst_nxt = 1'b1;
            frame_nxt = {CmdPrefix | {2'b00, IDX_CMD8}, if_cond_argument};
            crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_CMD8_TX;
          end
          PH_CMD8_RESP: begin
            if (r == R1Idle) begin
              word_nxt = '0; bc_nxt = '0; ph_nxt = PH_CMD8_R7;
            end else begin
              frame_nxt = {CmdPrefix | {2'b00, IDX_CMD58}, 32'd0};
              crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_OCR1_TX;
            end
          end
          PH_OCR1_RESP: begin
            if (r == R1Idle) begin
              word_nxt = '0; bc_nxt = '0; ph_nxt = PH_OCR1_R7;
            end else begin
              frame_nxt = {CmdPrefix | {2'b00, IDX_CMD55}, 32'd0};
              crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_CMD55_TX;
            end
          end
          PH_CMD55_RESP: begin
            if (r == R1Ready || r == R1Idle) begin
              frame_nxt = {CmdPrefix | {2'b00, IDX_ACMD41}, op_cond_argument};
              crc_nxt = '0; bc_nxt = '0; ph_nxt = PH_ACMD41_TX;
            end else begin
              ph_nxt = PH_ABORT;
            end
          end
          PH_ACMD41_RESP: begin
            word_nxt = {24'd0, r}; ph_nxt = PH_WAIT_OPCOND;
          end
          PH_OCR2_RESP: begin
            if (r == R1Ready || r == R1Idle) begin
              word_nxt = '0; bc_nxt = '0; ph_nxt = PH_OCR2_R7;
            end else begin
              ocr_nxt = '0; ph_nxt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end else if (q_op.is_delay) begin
      case (ph_r)
        PH_WAIT_POWER: begin
          bc_nxt = '0; ph_nxt = PH_DUMMY;
        end
        PH_WAIT_OPCOND: begin
          crc_nxt = '0; bc_nxt = '0;
          if (word_r == '0) begin
            frame_nxt = {CmdPrefix | {2'b00, IDX_CMD58}, 32'd0};
            ph_nxt = PH_OCR2_TX;
          end else begin
            frame_nxt = {CmdPrefix | {2'b00, IDX_CMD55}, 32'd0};
            ph_nxt = PH_CMD55_TX;
          end
        end
        default: ;
      endcase
    end
  end

  // Result from the state after this item.
  always_comb begin
    res_nxt = '0;
    case (ph_nxt)
      PH_IDLE: ;
      PH_WAIT_POWER: res_nxt.delay_request = DLY_SHORT;
      PH_WAIT_OPCOND: res_nxt.delay_request = DLY_LONG;
      PH_DUMMY: begin
        res_nxt.tx_valid = 1'b1; res_nxt.tx_byte = IdleByte;
      end
      PH_CMD0_TX, PH_CMD8_TX, PH_OCR1_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_OCR2_TX: begin
        res_nxt.tx_valid = 1'b1; res_nxt.select_active = 1'b1;
        if (bc_nxt < 8'd5) res_nxt.tx_byte = frame_nxt[39:32];
        else res_nxt.tx_byte = {crc_nxt, 1'b1};
      end
      PH_DONE: res_nxt.sequence_done = 1'b1;
      PH_ABORT: begin
        res_nxt.sequence_done = 1'b1; res_nxt.aborted = 1'b1;
      end
      default: begin
        res_nxt.tx_valid = 1'b1; res_nxt.tx_byte = IdleByte; res_nxt.select_active = 1'b1;
      end
    endcase
    res_nxt.reset_ok         = f_rst_nxt;
    res_nxt.if_cond_ok       = f_ifc_nxt;
    res_nxt.voltage_ok       = f_volt_nxt;
    res_nxt.response_timeout = f_to_nxt;
    res_nxt.ocr_value        = ocr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; bc_r <= '0; frame_r <= '0; crc_r <= '0; word_r <= '0;
      poll_r <= '0; f_rst_r <= 1'b0; f_ifc_r <= 1'b0; f_volt_r <= 1'b0;
      f_to_r <= 1'b0; ocr_r <= '0; res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        ph_r <= ph_nxt; bc_r <= bc_nxt; frame_r <= frame_nxt; crc_r <= crc_nxt;
        word_r <= word_nxt; poll_r <= poll_nxt; f_rst_r <= f_rst_nxt;
        f_ifc_r <= f_ifc_nxt; f_volt_r <= f_volt_nxt; f_to_r <= f_to_nxt;
        ocr_r <= ocr_nxt;
      end
      if (take) res_valid_r <= 1'b1;
      else if (res_ready) res_valid_r <= 1'b0;
    end
    if (take) res_r <= res_nxt;
  end

endmodule
